### rtl/core/tqlrc_pkg.sv
// shared constants, types and helpers for the q-learning rate controller
package tqlrc_pkg;

    // table geometry
    localparam int NUM_STATES = 256;
    localparam int TBL_DEPTH  = NUM_STATES * 2;
    localparam int ADDR_W     = $clog2(TBL_DEPTH);
    localparam int STATE_W    = $clog2(NUM_STATES);

    // fixed field widths
    localparam int FIT_W   = 32;
    localparam int RATE_W  = 25;
    localparam int GAIN_W  = 17;
    localparam int POP_W   = 16;
    localparam int SIDX_W  = 8;
    localparam int CFG_W   = 25;
    localparam int CIDX_W  = 3;

    // divider geometry: |child| * 65536 over |parent|
    localparam int DIVD_W  = 48;
    localparam int DIVS_W  = 32;
    localparam int DCNT_W  = $clog2(DIVD_W + 1);

    // multiplier geometry
    localparam int MA_W    = 34;
    localparam int MK_W    = GAIN_W + 1;
    localparam int MP_W    = MA_W + MK_W;

    // fixed point constants
    localparam logic [GAIN_W-1:0] GAIN_ONE  = GAIN_W'(65536);
    localparam logic [FIT_W-1:0]  Q16_ONE   = FIT_W'(65536);
    localparam int                TIE_DIV   = 20;

    // reward modes
    localparam logic [1:0] MODE_ABS   = 2'd0;
    localparam logic [1:0] MODE_BIN   = 2'd1;
    localparam logic [1:0] MODE_DIFF  = 2'd2;
    localparam logic [1:0] MODE_RATIO = 2'd3;

    // register indexes
    localparam logic [CIDX_W-1:0] REG_MODE  = 3'd0;
    localparam logic [CIDX_W-1:0] REG_ALPHA = 3'd1;
    localparam logic [CIDX_W-1:0] REG_GAMMA = 3'd2;
    localparam logic [CIDX_W-1:0] REG_MIN   = 3'd3;
    localparam logic [CIDX_W-1:0] REG_MAX   = 3'd4;
    localparam logic [CIDX_W-1:0] REG_START = 3'd5;
    localparam logic [CIDX_W-1:0] REG_POP   = 3'd6;

    // sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_REWARD,
        ST_DIV,
        ST_LEARN,
        ST_RD_D,
        ST_RD_O,
        ST_MUL_G,
        ST_TD,
        ST_MUL_A,
        ST_WR,
        ST_CH_M,
        ST_CH_D,
        ST_CHOOSE,
        ST_OUT
    } t_state;

    // saturate a signed value to 32 bits
    function automatic logic signed [FIT_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'sh0000_0000_7FFF_FFFF;
        lo = -64'sh0000_0000_8000_0000;
        if (v > hi) begin
            return 32'sh7FFF_FFFF;
        end else if (v < lo) begin
            return 32'sh8000_0000;
        end
        return v[FIT_W-1:0];
    endfunction

endpackage

### rtl/core/two_action_q_learning_rate_control.sv
// top level of the two-action q-learning rate controller
//
// channel   dir  handshake            payload
// input     in   i_valid / o_ready    start_run, prev_*, child/parent fitness, new_state
// result    out  o_valid / i_ready    chosen_action, rate_value, reward_value, divide_by_zero
// config    in   i_cfg_we             i_cfg_index, i_cfg_data (no wait, no read-back)
//
// an item that learns reads the table, multiplies by gamma, forms the td, multiplies
// by alpha and writes back before the choice; one that does not goes to the choice
// directly; ratio mode adds the serial divider that dominates. table reads and both
// multiplies share one memory port and one 34x18 multiplier. after reset a clearing
// pass zeroes the 512-entry table with o_ready low. a result waits in the output
// register; the next item is taken once the previous result has been moved into it.
module two_action_q_learning_rate_control
    import tqlrc_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CIDX_W-1:0]       i_cfg_index,
    input  logic [CFG_W-1:0]        i_cfg_data,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic                    i_start_run,
    input  logic                    i_prev_valid,
    input  logic [SIDX_W-1:0]       i_prev_state,
    input  logic                    i_prev_action,
    input  logic signed [FIT_W-1:0] i_child_fitness,
    input  logic signed [FIT_W-1:0] i_parent_fitness,
    input  logic [SIDX_W-1:0]       i_new_state,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic                    o_chosen_action,
    output logic [RATE_W-1:0]       o_rate_value,
    output logic signed [FIT_W-1:0] o_reward_value,
    output logic                    o_divide_by_zero
);

    localparam int TW = 24;

    // configuration registers
    logic [1:0]        r_mode;
    logic [GAIN_W-1:0] r_alpha;
    logic [GAIN_W-1:0] r_gamma;
    logic [RATE_W-1:0] r_min;
    logic [RATE_W-1:0] r_max;
    logic [RATE_W-1:0] r_start;
    logic [POP_W-1:0]  r_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_DIFF;
            r_alpha <= GAIN_W'(6554);
            r_gamma <= GAIN_W'(62259);
            r_min   <= RATE_W'(65536);
            r_max   <= RATE_W'(8388608);
            r_start <= RATE_W'(65536);
            r_pop   <= POP_W'(100);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_MODE:  r_mode  <= i_cfg_data[1:0];
                REG_ALPHA: r_alpha <= i_cfg_data[GAIN_W-1:0];
                REG_GAMMA: r_gamma <= i_cfg_data[GAIN_W-1:0];
                REG_MIN:   r_min   <= i_cfg_data[RATE_W-1:0];
                REG_MAX:   r_max   <= i_cfg_data[RATE_W-1:0];
                REG_START: r_start <= i_cfg_data[RATE_W-1:0];
                REG_POP:   r_pop   <= i_cfg_data[POP_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer and item registers
    t_state                  r_state, n_state;
    logic [ADDR_W-1:0]       r_clr;
    logic                    r_pv;
    logic [STATE_W-1:0]      r_ps;
    logic                    r_pa;
    logic signed [FIT_W-1:0] r_child;
    logic signed [FIT_W-1:0] r_parent;
    logic [STATE_W-1:0]      r_ns;
    logic signed [FIT_W-1:0] r_reward;
    logic                    r_dz;
    logic signed [FIT_W-1:0] r_nm;
    logic signed [FIT_W-1:0] r_nd;
    logic signed [FIT_W-1:0] r_old;
    logic signed [MA_W-1:0]  r_td;
    logic signed [MP_W-1:0]  r_prod;
    logic [RATE_W-1:0]       r_rate;
    logic                    r_act;
    logic                    r_ovalid;
    logic                    r_oact;
    logic [RATE_W-1:0]       r_orate;
    logic signed [FIT_W-1:0] r_oreward;
    logic                    r_odz;

    // table memory
    logic signed [FIT_W-1:0] r_mem [TBL_DEPTH];
    logic signed [FIT_W-1:0] r_rdata;
    logic [ADDR_W-1:0]       n_addr;
    logic                    n_we;
    logic [ADDR_W-1:0]       n_waddr;
    logic signed [FIT_W-1:0] n_wdata;

    always_ff @(posedge i_clk) begin
        if (n_we) begin
            r_mem[n_waddr] <= n_wdata;
        end
        r_rdata <= r_mem[n_addr];
    end

    // state index clamp
    function automatic logic [STATE_W-1:0] sidx(input logic [SIDX_W-1:0] s);
        logic [TW-1:0] w;
        w = TW'(s);
        if (w >= TW'(NUM_STATES)) begin
            return STATE_W'(NUM_STATES - 1);
        end
        return w[STATE_W-1:0];
    endfunction

    logic [ADDR_W-1:0] w_ns_m, w_ns_d, w_slot;
    assign w_ns_m = {r_ns, 1'b0};
    assign w_ns_d = {r_ns, 1'b1};
    assign w_slot = {r_ps, r_pa};

    // divider for ratio mode
    logic              n_div_start;
    logic              w_div_done;
    logic [DIVD_W-1:0] w_quo;
    logic [FIT_W-1:0]  w_cabs, w_pabs;

    assign w_cabs = r_child[FIT_W-1]  ? FIT_W'(-r_child)  : r_child;
    assign w_pabs = r_parent[FIT_W-1] ? FIT_W'(-r_parent) : r_parent;

    tqlrc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (n_div_start),
        .i_dividend ({w_cabs, 16'h0000}),
        .i_divisor  (w_pabs),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    // ratio reward from the quotient
    logic signed [63:0] w_qs;
    assign w_qs = (r_child[FIT_W-1] ^ r_parent[FIT_W-1])
                ? -$signed({16'h0000, w_quo}) - 64'sd65536
                :  $signed({16'h0000, w_quo}) - 64'sd65536;

    // direct reward for the other modes and for ratio mode with a zero parent
    logic signed [FIT_W-1:0] n_rew;
    logic                    n_dz;
    logic signed [63:0]      w_diff;
    assign w_diff = 64'(r_child) - 64'(r_parent);

    always_comb begin
        n_dz  = 1'b0;
        n_rew = r_child;
        unique case (r_mode)
            MODE_ABS:  n_rew = r_child;
            MODE_BIN:  n_rew = (r_child > r_parent) ? $signed(Q16_ONE) : '0;
            MODE_DIFF: n_rew = sat32(w_diff);
            MODE_RATIO: begin
                n_dz = (r_parent == '0);
                if (r_child > 0) begin
                    n_rew = 32'sh7FFF_FFFF;
                end else if (r_child < 0) begin
                    n_rew = 32'sh8000_0000;
                end else begin
                    n_rew = -$signed(Q16_ONE);
                end
            end
            default: ;
        endcase
    end

    // shared multiplier, product registered
    logic signed [MA_W-1:0]  n_ma;
    logic [GAIN_W-1:0]       n_mk;
    logic signed [FIT_W-1:0] w_best;
    assign w_best = (r_nd > r_nm) ? r_nd : r_nm;

    always_comb begin
        if (r_state == ST_MUL_A) begin
            n_ma = r_td;
            n_mk = (r_alpha > GAIN_ONE) ? GAIN_ONE : r_alpha;
        end else begin
            n_ma = MA_W'(w_best);
            n_mk = (r_gamma > GAIN_ONE) ? GAIN_ONE : r_gamma;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_ma * $signed({1'b0, n_mk});
    end

    // td and new q value
    logic signed [MA_W-1:0] w_gterm;
    logic signed [63:0]     w_newq;
    assign w_gterm = r_prod[MA_W+15:16];
    assign w_newq  = 64'(r_old) + 64'($signed(r_prod[MP_W-2:16]));

    // action choice and rate update
    logic          w_tie_mul;
    logic          w_mul;
    logic [TW-1:0] w_scaled;
    logic [RATE_W:0] w_dbl;
    logic [RATE_W-1:0] w_half;
    assign w_scaled  = TW'(TIE_DIV) * (TW'(r_ns) + TW'(1));
    assign w_tie_mul = (r_ns != '0) && (w_scaled > TW'(r_pop));
    assign w_mul     = (r_nm > r_rdata) || ((r_nm == r_rdata) && w_tie_mul);
    assign w_dbl     = {r_rate, 1'b0};
    assign w_half    = r_rate >> 1;

    // next state and memory control
    always_comb begin
        n_state     = r_state;
        n_addr      = w_ns_m;
        n_we        = 1'b0;
        n_waddr     = r_clr;
        n_wdata     = '0;
        n_div_start = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                n_we = 1'b1;
                if (r_clr == ADDR_W'(TBL_DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_REWARD;
                end
            end
            ST_REWARD: begin
                if (r_mode == MODE_RATIO && r_parent != '0) begin
                    n_div_start = 1'b1;
                    n_state     = ST_DIV;
                end else begin
                    n_state = ST_LEARN;
                end
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_state = ST_LEARN;
                end
            end
            ST_LEARN: begin
                n_addr  = w_ns_m;
                n_state = r_pv ? ST_RD_D : ST_CH_M;
            end
            ST_RD_D: begin
                n_addr  = w_ns_d;
                n_state = ST_RD_O;
            end
            ST_RD_O: begin
                n_addr  = w_slot;
                n_state = ST_MUL_G;
            end
            ST_MUL_G:  n_state = ST_TD;
            ST_TD:     n_state = ST_MUL_A;
            ST_MUL_A:  n_state = ST_WR;
            ST_WR: begin
                n_we    = 1'b1;
                n_waddr = w_slot;
                n_wdata = sat32(w_newq);
                n_state = ST_CH_M;
            end
            ST_CH_M: begin
                n_addr  = w_ns_m;
                n_state = ST_CH_D;
            end
            ST_CH_D: begin
                n_addr  = w_ns_d;
                n_state = ST_CHOOSE;
            end
            ST_CHOOSE: n_state = ST_OUT;
            ST_OUT: begin
                if (!r_ovalid || i_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
        end
    end

    // item datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate <= RATE_W'(65536);
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_pv     <= i_prev_valid;
                        r_ps     <= sidx(i_prev_state);
                        r_pa     <= i_prev_action;
                        r_child  <= i_child_fitness;
                        r_parent <= i_parent_fitness;
                        r_ns     <= sidx(i_new_state);
                        if (i_start_run) begin
                            r_rate <= r_start;
                        end
                    end
                end
                ST_REWARD: begin
                    r_reward <= n_rew;
                    r_dz     <= n_dz;
                end
                ST_DIV: begin
                    if (w_div_done) begin
                        r_reward <= sat32(w_qs);
                    end
                end
                ST_RD_D:  r_nm  <= r_rdata;
                ST_RD_O:  r_nd  <= r_rdata;
                ST_MUL_G: r_old <= r_rdata;
                ST_TD: begin
                    r_td <= MA_W'(r_reward) + w_gterm - MA_W'(r_old);
                end
                ST_CHOOSE: begin
                    r_act <= !w_mul;
                    if (w_mul) begin
                        r_rate <= (w_dbl < {1'b0, r_max}) ? w_dbl[RATE_W-1:0] : r_max;
                    end else begin
                        r_rate <= (w_half > r_min) ? w_half : r_min;
                    end
                end
                ST_CH_D: r_nm <= r_rdata;
                default: ;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else begin
            if (r_state == ST_OUT && (!r_ovalid || i_ready)) begin
                r_ovalid  <= 1'b1;
                r_oact    <= r_act;
                r_orate   <= r_rate;
                r_oreward <= r_reward;
                r_odz     <= r_dz;
            end else if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_ready          = (r_state == ST_IDLE);
    assign o_valid          = r_ovalid;
    assign o_chosen_action  = r_oact;
    assign o_rate_value     = r_orate;
    assign o_reward_value   = r_oreward;
    assign o_divide_by_zero = r_odz;

endmodule

### rtl/core/tqlrc_div.sv
// restoring unsigned divider, one quotient bit per cycle
module tqlrc_div
    import tqlrc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIVD_W-1:0] i_dividend,
    input  logic [DIVS_W-1:0] i_divisor,
    output logic              o_done,
    output logic [DIVD_W-1:0] o_quotient
);

    logic              r_busy;
    logic              r_done;
    logic [DCNT_W-1:0] r_cnt;
    logic [DIVD_W-1:0] r_quo;
    logic [DIVS_W:0]   r_rem;
    logic [DIVS_W-1:0] r_dvs;

    logic [DIVS_W+1:0] n_shift;
    logic [DIVS_W+1:0] n_diff;

    // trial subtract of the shifted remainder
    always_comb begin
        n_shift = {r_rem, r_quo[DIVD_W-1]};
        n_diff  = n_shift - {2'b00, r_dvs};
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DCNT_W'(DIVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DCNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath; quotient bits shift in where dividend bits leave
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            if (!n_diff[DIVS_W+1]) begin
                r_rem <= n_diff[DIVS_W:0];
                r_quo <= {r_quo[DIVD_W-2:0], 1'b1};
            end else begin
                r_rem <= n_shift[DIVS_W:0];
                r_quo <= {r_quo[DIVD_W-2:0], 1'b0};
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule
